### design/sgs_pkg.sv
// Shared types and constants for the scaffold gap segmenter.
`timescale 1ns / 1ps

package sgs_pkg;

  // Default width of the position and run counters
  localparam int unsigned POS_BITS_DEF = 32;

  // Unknown-base characters
  localparam logic [7:0] CHAR_N_UP = 8'h4E;
  localparam logic [7:0] CHAR_N_LO = 8'h6E;

  // Record queue: power of two, at least three (one beat can make three records)
  localparam int unsigned REC_DEPTH = 4;
  localparam int unsigned REC_PTR_W = $clog2(REC_DEPTH);
  localparam int unsigned REC_CNT_W = $clog2(REC_DEPTH + 1);
  localparam int unsigned REC_SLOTS = 3;

  typedef enum logic {
    KIND_CONTIG = 1'b0,
    KIND_GAP    = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] index;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [31:0] gap_len;
    logic        last;
  } rec_t;

  // Records made by one base, in output order: closing contig, gap, final contig
  typedef struct packed {
    logic [REC_SLOTS-1:0] vld;
    rec_t [REC_SLOTS-1:0] rec;
  } push_t;

endpackage

### design/sgs_core.sv
// Base input register, scaffold state and record generation.
`timescale 1ns / 1ps

module sgs_core import sgs_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  base_i,
  input  logic        last_base_i,
  input  logic [31:0] min_gap_i,
  input  logic        room_i,
  output push_t       push_o
);

  localparam int unsigned WIDE = POS_BITS + 32;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // Input register
  logic       item_vld_q;
  logic [7:0] base_q;
  logic       last_q;
  logic       advance;

  // Scaffold state
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] run_len_q, run_len_d;
  logic [POS_BITS-1:0] run_start_q, run_start_d;
  logic [POS_BITS-1:0] cstart_q, cstart_d;
  logic                copen_q, copen_d;
  logic [31:0]         ccount_q, ccount_d;
  logic [31:0]         gcount_q, gcount_d;

  // Working values
  logic                is_n;
  logic [POS_BITS-1:0] rs, rl, cur_start, cur_len, new_cstart;
  logic                long_run, gap_v, close_v, final_v;
  logic [WIDE-1:0]     close_end_w, gap_end_w, cur_start_w, cur_len_w;
  logic [WIDE-1:0]     pos_w, new_cstart_w, cstart_w;

  assign advance    = item_vld_q && room_i;
  assign in_ready_o = !item_vld_q || advance;

  // Input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      base_q <= base_i;
      last_q <= last_base_i;
    end
  end

  // Classify the base and the run it extends or ends
  always_comb begin
    is_n       = (base_q == CHAR_N_UP) || (base_q == CHAR_N_LO);
    rs         = (run_len_q == '0) ? pos_q : run_start_q;
    rl         = (run_len_q == POS_MAX) ? run_len_q : run_len_q + POS_BITS'(1);
    cur_start  = is_n ? rs : run_start_q;
    cur_len    = is_n ? rl : run_len_q;
    long_run   = WIDE'(cur_len) > WIDE'(min_gap_i);
    gap_v      = is_n ? (last_q && long_run) : long_run;
    close_v    = copen_q && (is_n ? last_q : long_run);
    final_v    = !is_n && last_q;
    new_cstart = (copen_q && !close_v) ? cstart_q : pos_q;

    cur_start_w  = WIDE'(cur_start);
    cur_len_w    = WIDE'(cur_len);
    pos_w        = WIDE'(pos_q);
    new_cstart_w = WIDE'(new_cstart);
    cstart_w     = WIDE'(cstart_q);
    close_end_w  = cur_start_w - WIDE'(1);
    gap_end_w    = cur_start_w + cur_len_w - WIDE'(1);
  end

  // Record slots
  always_comb begin
    push_o = '0;
    push_o.vld = advance ? {final_v, gap_v, close_v} : '0;

    push_o.rec[0].kind      = KIND_CONTIG;
    push_o.rec[0].index     = ccount_q;
    push_o.rec[0].start_pos = cstart_w[31:0];
    push_o.rec[0].end_pos   = close_end_w[31:0];
    push_o.rec[0].gap_len   = '0;
    push_o.rec[0].last      = last_q && !gap_v && !final_v;

    push_o.rec[1].kind      = KIND_GAP;
    push_o.rec[1].index     = gcount_q;
    push_o.rec[1].start_pos = cur_start_w[31:0];
    push_o.rec[1].end_pos   = gap_end_w[31:0];
    push_o.rec[1].gap_len   = cur_len_w[31:0];
    push_o.rec[1].last      = last_q && !final_v;

    push_o.rec[2].kind      = KIND_CONTIG;
    push_o.rec[2].index     = ccount_q + 32'(close_v);
    push_o.rec[2].start_pos = new_cstart_w[31:0];
    push_o.rec[2].end_pos   = pos_w[31:0];
    push_o.rec[2].gap_len   = '0;
    push_o.rec[2].last      = last_q;
  end

  // State update, cleared at the end of each scaffold
  always_comb begin
    pos_d       = pos_q;
    run_len_d   = run_len_q;
    run_start_d = run_start_q;
    cstart_d    = cstart_q;
    copen_d     = copen_q;
    ccount_d    = ccount_q;
    gcount_d    = gcount_q;
    if (advance) begin
      if (last_q) begin
        pos_d       = '0;
        run_len_d   = '0;
        run_start_d = '0;
        cstart_d    = '0;
        copen_d     = 1'b0;
        ccount_d    = '0;
        gcount_d    = '0;
      end else begin
        pos_d    = (pos_q == POS_MAX) ? pos_q : pos_q + POS_BITS'(1);
        ccount_d = ccount_q + 32'(close_v);
        gcount_d = gcount_q + 32'(gap_v);
        if (is_n) begin
          run_start_d = rs;
          run_len_d   = rl;
        end else begin
          run_len_d = '0;
          copen_d   = 1'b1;
          cstart_d  = new_cstart;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      run_len_q   <= '0;
      run_start_q <= '0;
      cstart_q    <= '0;
      copen_q     <= 1'b0;
      ccount_q    <= '0;
      gcount_q    <= '0;
    end else begin
      pos_q       <= pos_d;
      run_len_q   <= run_len_d;
      run_start_q <= run_start_d;
      cstart_q    <= cstart_d;
      copen_q     <= copen_d;
      ccount_q    <= ccount_d;
      gcount_q    <= gcount_d;
    end
  end

  // A processed last base leaves a fresh scaffold behind
  a_scaffold_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q |=> pos_q == '0 && run_len_q == '0 && !copen_q)
    else $error("scaffold state not cleared after last base");

  // At most one record of a beat is flagged last
  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({push_o.vld[2] && push_o.rec[2].last,
              push_o.vld[1] && push_o.rec[1].last,
              push_o.vld[0] && push_o.rec[0].last}))
    else $error("more than one last record in a beat");

  // Records only come from a beat that was taken into the state
  a_push_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.vld != '0 |-> advance)
    else $error("record pushed without a processed beat");

endmodule

### design/sgs_rec_fifo.sv
// Record queue: takes up to three records a cycle, hands out one a cycle while the reader is ready.
`timescale 1ns / 1ps

module sgs_rec_fifo import sgs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output rec_t  rec_o
);

  rec_t                 mem_q [REC_DEPTH];
  logic [REC_PTR_W-1:0] wr_q, rd_q;
  logic [REC_CNT_W-1:0] cnt_q;
  logic [REC_CNT_W-1:0] n_push;
  logic [REC_PTR_W-1:0] off1, off2;
  logic                 pop;

  // Slot write addresses pack the valid records back to back
  assign off1   = wr_q + REC_PTR_W'(push_i.vld[0]);
  assign off2   = off1 + REC_PTR_W'(push_i.vld[1]);
  assign n_push = REC_CNT_W'(push_i.vld[0]) + REC_CNT_W'(push_i.vld[1])
                + REC_CNT_W'(push_i.vld[2]);

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = cnt_q <= REC_CNT_W'(REC_DEPTH - REC_SLOTS);
  assign rec_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.vld[0]) begin
      mem_q[wr_q] <= push_i.rec[0];
    end
    if (push_i.vld[1]) begin
      mem_q[off1] <= push_i.rec[1];
    end
    if (push_i.vld[2]) begin
      mem_q[off2] <= push_i.rec[2];
    end
  end

  // Pointers wrap naturally at the power-of-two depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + REC_PTR_W'(n_push);
      rd_q  <= rd_q + REC_PTR_W'(pop);
      cnt_q <= cnt_q + n_push - REC_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= REC_CNT_W'(REC_DEPTH))
    else $error("record queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.vld != '0 |-> cnt_q <= REC_CNT_W'(REC_DEPTH - REC_SLOTS))
    else $error("records pushed without room");

endmodule

### design/scaffold_gap_segmenter_top.sv
// Scaffold gap segmenter: min_gap register, base stage and record queue.
// Path: an accepted base waits in the base register until the record queue has room,
//   then its records are written into the record queue and handed out from there.
// Throughput: one base per cycle while bases make at most one record each and the reader
//   takes records; a base that makes two or three records drains them one per beat from the 4-entry queue.
// Reset: clears position, runs, contig state, counters and min_gap (to 0).
`timescale 1ns / 1ps

module scaffold_gap_segmenter_top import sgs_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  base_i,
  input  logic        last_base_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        record_kind_o,
  output logic [31:0] record_index_o,
  output logic [31:0] start_pos_o,
  output logic [31:0] end_pos_o,
  output logic [31:0] gap_length_o,
  output logic        last_record_o
);

  logic [31:0] min_gap_q;
  logic        room;
  push_t       push;
  rec_t        rec;

  // min_gap register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q <= '0;
    end else if (cfg_we_i) begin
      min_gap_q <= cfg_wdata_i;
    end
  end

  sgs_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .base_i      (base_i),
    .last_base_i (last_base_i),
    .min_gap_i   (min_gap_q),
    .room_i      (room),
    .push_o      (push)
  );

  sgs_rec_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (rec)
  );

  assign record_kind_o  = rec.kind;
  assign record_index_o = rec.index;
  assign start_pos_o    = rec.start_pos;
  assign end_pos_o      = rec.end_pos;
  assign gap_length_o   = rec.gap_len;
  assign last_record_o  = rec.last;

endmodule
